[design/sdde_pkg.sv]
// ----------------------------------------------------------------------------
// sdde_pkg
// Shared types and codes for the SDP data element decoder.
// ----------------------------------------------------------------------------
package sdde_pkg;

    // Header type codes (upper five bits of the header byte)
    localparam logic [4:0] TYPE_NIL    = 5'd0;
    localparam logic [4:0] TYPE_UINT   = 5'd1;
    localparam logic [4:0] TYPE_INT    = 5'd2;
    localparam logic [4:0] TYPE_UUID   = 5'd3;
    localparam logic [4:0] TYPE_STRING = 5'd4;
    localparam logic [4:0] TYPE_BOOL   = 5'd5;
    localparam logic [4:0] TYPE_SEQ    = 5'd6;
    localparam logic [4:0] TYPE_ALT    = 5'd7;
    localparam logic [4:0] TYPE_URL    = 5'd8;

    // Size descriptors that matter
    localparam logic [2:0] SIZE_1B    = 3'd0;
    localparam logic [2:0] SIZE_2B    = 3'd1;
    localparam logic [2:0] SIZE_4B    = 3'd2;
    localparam logic [2:0] SIZE_16B   = 3'd4;
    localparam logic [2:0] SIZE_LEN8  = 3'd5;
    localparam logic [2:0] SIZE_LEN16 = 3'd6;
    localparam logic [2:0] SIZE_LEN32 = 3'd7;

    // Dense subtype codes
    localparam logic [3:0] SUB_NONE    = 4'd0;
    localparam logic [3:0] SUB_UINT8   = 4'd1;
    localparam logic [3:0] SUB_INT8    = 4'd6;
    localparam logic [3:0] SUB_UUID16  = 4'd11;
    localparam logic [3:0] SUB_UUID32  = 4'd12;
    localparam logic [3:0] SUB_UUID128 = 4'd13;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIXED = 2'd1,
        PH_LEN   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0] stream_length;
        logic        start_element;
        logic [7:0]  data_byte;
    } sdde_in_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  element_type;
        logic [3:0]  subtype;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic [2:0]  payload_offset;
        logic [31:0] payload_length;
        logic [31:0] bytes_consumed;
    } sdde_res_t;

endpackage

[design/sdde_in_stage.sv]
// ----------------------------------------------------------------------------
// sdde_in_stage
// Input register: captures one stream beat and holds it until the decoder
// consumes it.
// ----------------------------------------------------------------------------
module sdde_in_stage
    import sdde_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  sdde_in_t in_data,
    input  logic     consume,
    output logic     held_valid,
    output sdde_in_t held_data
);

    logic     vld_reg, vld_next;
    sdde_in_t data_reg;

    assign in_ready = !vld_reg || consume;

    always_comb begin
        vld_next = vld_reg;
        if (in_ready) begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign held_valid = vld_reg;
    assign held_data  = data_reg;

endmodule

[design/sdde_step.sv]
// ----------------------------------------------------------------------------
// sdde_step
// Element decoder: header checks, big-endian gathering and length checks,
// with the parse state registers.
// ----------------------------------------------------------------------------
module sdde_step
    import sdde_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  sdde_in_t  beat,
    output logic      has_result,
    output sdde_res_t result
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  type_reg, type_next;
    logic [2:0]  size_reg, size_next;
    logic [4:0]  need_reg, need_next;
    logic [63:0] vhi_reg, vhi_next;
    logic [63:0] vlo_reg, vlo_next;
    logic [31:0] rem_reg, rem_next;

    logic [4:0]   hdr_type;
    logic [2:0]   hdr_size;
    logic [31:0]  hdr_rem;
    logic [4:0]   hdr_n;
    logic         hdr_bad;
    logic         hdr_nil;
    logic         hdr_len;
    logic [127:0] shifted;
    logic [4:0]   need_dec;
    logic [2:0]   lbytes;
    logic [31:0]  elems;
    logic [31:0]  avail;
    logic [32:0]  total;
    logic [31:0]  total_sat;
    logic [31:0]  fixed_used;
    logic [3:0]   fixed_sub;

    assign hdr_type = beat.data_byte[7:3];
    assign hdr_size = beat.data_byte[2:0];
    assign hdr_rem  = beat.stream_length - 32'd1;
    assign shifted  = {vhi_reg[55:0], vlo_reg, beat.data_byte};
    assign need_dec = (need_reg != 5'd0) ? need_reg - 5'd1 : need_reg;

    // header legality and size of the following field
    always_comb begin
        hdr_n   = 5'd0;
        hdr_bad = 1'b0;
        hdr_nil = 1'b0;
        hdr_len = 1'b0;
        unique case (hdr_type)
            TYPE_NIL: begin
                hdr_nil = 1'b1;
                hdr_bad = (hdr_size != SIZE_1B);
            end
            TYPE_UINT, TYPE_INT: begin
                hdr_bad = (hdr_size > SIZE_16B);
                hdr_n   = 5'd1 << hdr_size;
            end
            TYPE_UUID: begin
                unique case (hdr_size)
                    SIZE_2B:  hdr_n = 5'd2;
                    SIZE_4B:  hdr_n = 5'd4;
                    SIZE_16B: hdr_n = 5'd16;
                    default:  hdr_bad = 1'b1;
                endcase
            end
            TYPE_BOOL: begin
                hdr_bad = (hdr_size != SIZE_1B);
                hdr_n   = 5'd1;
            end
            TYPE_STRING, TYPE_SEQ, TYPE_ALT, TYPE_URL: begin
                hdr_len = 1'b1;
                hdr_bad = (hdr_size < SIZE_LEN8);
                hdr_n   = (hdr_size == SIZE_LEN8) ? 5'd1 :
                          (hdr_size == SIZE_LEN16) ? 5'd2 : 5'd4;
            end
            default: hdr_bad = 1'b1;
        endcase
    end

    // figures for the end of a fixed value or a length field
    always_comb begin
        lbytes    = (size_reg == SIZE_LEN8) ? 3'd1 :
                    (size_reg == SIZE_LEN16) ? 3'd2 : 3'd4;
        elems     = shifted[31:0];
        avail     = rem_reg - {29'd0, lbytes};
        total     = 33'd1 + {30'd0, lbytes} + {1'b0, elems};
        total_sat = total[32] ? 32'hFFFF_FFFF : total[31:0];

        if (type_reg == TYPE_BOOL) begin
            fixed_used = 32'd2;
        end else if (type_reg == TYPE_UUID) begin
            fixed_used = (size_reg == SIZE_16B) ? 32'd17 :
                         (size_reg == SIZE_2B) ? 32'd3 : 32'd5;
        end else begin
            fixed_used = 32'd1 + (32'd1 << size_reg);
        end

        unique case (type_reg)
            TYPE_UINT: fixed_sub = SUB_UINT8 + {1'b0, size_reg};
            TYPE_INT:  fixed_sub = SUB_INT8 + {1'b0, size_reg};
            TYPE_UUID: fixed_sub = (size_reg == SIZE_2B) ? SUB_UUID16 :
                                   (size_reg == SIZE_4B) ? SUB_UUID32 : SUB_UUID128;
            default:   fixed_sub = SUB_NONE;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        need_next  = need_reg;
        vhi_next   = vhi_reg;
        vlo_next   = vlo_reg;
        rem_next   = rem_reg;
        has_result = 1'b0;
        result     = '0;

        if (beat.start_element) begin
            // new header: drop whatever element was in progress
            phase_next = PH_IDLE;
            type_next  = hdr_type;
            size_next  = hdr_size;
            need_next  = 5'd0;
            vhi_next   = '0;
            vlo_next   = '0;
            if (beat.stream_length == 32'd0) begin
                has_result    = 1'b1;
                result.status = STATUS_ERR;
            end else begin
                rem_next = hdr_rem;
                if (hdr_bad || hdr_rem < {27'd0, hdr_n}) begin
                    has_result    = 1'b1;
                    result.status = STATUS_ERR;
                end else if (hdr_nil) begin
                    has_result            = 1'b1;
                    result.status         = STATUS_OK;
                    result.bytes_consumed = 32'd1;
                end else begin
                    need_next  = hdr_n;
                    phase_next = hdr_len ? PH_LEN : PH_FIXED;
                end
            end
        end else if (phase_reg == PH_FIXED || phase_reg == PH_LEN) begin
            vhi_next  = shifted[127:64];
            vlo_next  = shifted[63:0];
            need_next = need_dec;
            if (need_dec == 5'd0) begin
                phase_next = PH_IDLE;
                has_result = 1'b1;
                if (phase_reg == PH_FIXED) begin
                    result.status         = STATUS_OK;
                    result.element_type   = type_reg[3:0];
                    result.subtype        = fixed_sub;
                    result.value_high     = shifted[127:64];
                    result.value_low      = shifted[63:0];
                    result.bytes_consumed = fixed_used;
                end else if (avail < elems) begin
                    result.status = STATUS_ERR;
                end else begin
                    result.status         = STATUS_OK;
                    result.element_type   = type_reg[3:0];
                    result.bytes_consumed = total_sat;
                    if (type_reg == TYPE_STRING || type_reg == TYPE_URL) begin
                        result.payload_offset = 3'd1 + lbytes;
                        result.payload_length = elems;
                    end else begin
                        result.payload_length = total_sat;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            type_reg  <= '0;
            size_reg  <= '0;
            need_reg  <= '0;
            vhi_reg   <= '0;
            vlo_reg   <= '0;
            rem_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            need_reg  <= need_next;
            vhi_reg   <= vhi_next;
            vlo_reg   <= vlo_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

[design/sdde_out_stage.sv]
// ----------------------------------------------------------------------------
// sdde_out_stage
// Result register: holds one decoded element until the master side takes it.
// ----------------------------------------------------------------------------
module sdde_out_stage
    import sdde_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  sdde_res_t load_data,
    output logic      out_valid,
    input  logic      out_ready,
    output sdde_res_t out_data,
    output logic      can_load
);

    logic      vld_reg, vld_next;
    sdde_res_t data_reg;

    assign can_load = !vld_reg || out_ready;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

[design/sdp_data_element_decoder_core.sv]
// ----------------------------------------------------------------------------
// sdp_data_element_decoder_core
// Byte-serial decoder for one SDP data element per header.
//
//   channel   dir  tdata                              tuser
//   s_        in   data_byte, stream_length           start_element
//   m_        out  type, subtype, value, offset, ...  status
//
// One beat a cycle unless stalled: a byte enters the input register, is
// decoded from there and its result (if any) lands in the result register.
// A full result register that is not taken stalls the decoder and, once the
// input register is full too, s_tready.
// Reset clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module sdp_data_element_decoder_core
    import sdde_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [7:0] data_byte, [39:8] stream_length
    input  logic         s_tuser,   // [0] start_element
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] element_type, [7:4] subtype, [71:8] value_high,
    // [135:72] value_low, [138:136] payload_offset,
    // [170:139] payload_length, [202:171] bytes_consumed, [207:203] zero
    output logic [207:0] m_tdata,
    output logic         m_tuser    // [0] status
);

    sdde_in_t  in_beat;
    sdde_in_t  held_beat;
    logic      held_valid;
    logic      consume;
    logic      can_load;
    logic      has_result;
    sdde_res_t step_res;
    sdde_res_t out_res;

    assign in_beat.data_byte     = s_tdata[7:0];
    assign in_beat.stream_length = s_tdata[39:8];
    assign in_beat.start_element = s_tuser;

    // advance the decoder only when a result can be parked behind it
    assign consume = held_valid && can_load;

    sdde_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (in_beat),
        .consume    (consume),
        .held_valid (held_valid),
        .held_data  (held_beat)
    );

    sdde_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (consume),
        .beat       (held_beat),
        .has_result (has_result),
        .result     (step_res)
    );

    sdde_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (consume && has_result),
        .load_data (step_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .can_load  (can_load)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {5'd0,
                      out_res.bytes_consumed,
                      out_res.payload_length,
                      out_res.payload_offset,
                      out_res.value_low,
                      out_res.value_high,
                      out_res.subtype,
                      out_res.element_type};

    // an error result carries nothing but the status flag
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_ERR) |-> (m_tdata == '0))
        else $error("error result with nonzero payload");

    // an empty input register always takes a beat
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_valid |-> s_tready)
        else $error("input stage empty but not ready");

    // a new result only appears after the decoder advanced
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(consume))
        else $error("result without a decoded beat");

    // content offset of a good element never exceeds header plus 32-bit length
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_OK) |-> (m_tdata[138:136] <= 3'd5))
        else $error("payload offset out of range");

endmodule
